[hdl/tssb_pkg.sv]
// Shared types and constants for the three-stack shared buffer.
// Used by tssb_ctrl, tssb_datapath and three_stack_shared_buffer; no dependencies.
package tssb_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int NUM_STACKS      = 3;
    localparam int CAP_W           = 9;
    localparam int DATA_W          = 32;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // value of the top paddr bit that selects the capacity register on the config port
    localparam logic REG_STACK_CAPACITY = 1'b0;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_PEEK  = 2'd2;
    localparam logic [1:0] ACT_QUERY = 2'd3;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic [1:0] SEL_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]               action;
        logic [1:0]               stack_select;
        logic signed [DATA_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     stack_empty;
        logic [1:0]               status;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

[hdl/three_stack_shared_buffer.sv]
// Top level: three LIFO stacks in one shared store, APB capacity register.
// Depends on tssb_pkg, tssb_ctrl and tssb_datapath.
//
//  channel  | signals                              | handshake
//  ---------+--------------------------------------+------------------------------
//  item in  | i_item                               | start high while busy low
//  result   | o_result                             | o_done high for one cycle
//  config   | psel penable pwrite paddr pwdata ... | APB, pready tied high
//
// Each item passes through accept, execute (one fill counter and one store
// access on the single store port) and present result. busy stays high from
// the accept edge until the result cycle ends, so a new item is taken only after the last result.
// Reset clears the fill counts and sets capacity to 256; the store is left
// as is. The receiver cannot stall: o_done marks each result for exactly one cycle.
module three_stack_shared_buffer #(
    parameter int STACK_DEPTH = tssb_pkg::STACK_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tssb_pkg::t_in_item            i_item,
    output logic                          o_done,
    output tssb_pkg::t_out_item           o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tssb_pkg::PADDR_W-1:0]  paddr,
    input  logic [tssb_pkg::PDATA_W-1:0]  pwdata,
    output logic [tssb_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import tssb_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    t_dp_cmd          cmd;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1] == REG_STACK_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = reg_sel ? PDATA_W'(r_capacity) : '0;

    tssb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    tssb_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_item),
        .i_capacity (r_capacity),
        .o_result   (o_result)
    );

endmodule

[hdl/tssb_ctrl.sv]
// Sequencer for the three-stack shared buffer: accept, execute, respond.
// Depends on tssb_pkg for the datapath command struct.
module tssb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    output logic             o_done,
    output tssb_pkg::t_dp_cmd o_cmd
);
    import tssb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC:  n_state = S_RESP;
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_done     = (r_state == S_RESP);
    assign o_cmd.load = (r_state == S_IDLE) && i_start;
    assign o_cmd.exec = (r_state == S_EXEC);

endmodule

[hdl/tssb_datapath.sv]
// Datapath: item register, fill counters, shared store and result registers.
// Depends on tssb_pkg for item types, action and status codes.
module tssb_datapath #(
    parameter int STACK_DEPTH = tssb_pkg::STACK_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tssb_pkg::t_dp_cmd           i_cmd,
    input  tssb_pkg::t_in_item          i_item,
    input  logic [tssb_pkg::CAP_W-1:0]  i_capacity,
    output tssb_pkg::t_out_item         o_result
);
    import tssb_pkg::*;

    localparam int MEM_DEPTH = NUM_STACKS * STACK_DEPTH;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    // sel*cap + fill stays at or below 3*511 for any capacity the register holds
    localparam int IW        = (AW > 11) ? AW : 11;
    localparam int CAP_MAX   = (1 << CAP_W) - 1;
    localparam logic [CAP_W-1:0] CAP_LIMIT =
        CAP_W'((STACK_DEPTH > CAP_MAX) ? CAP_MAX : STACK_DEPTH);

    logic [DATA_W-1:0] mem [MEM_DEPTH];

    t_in_item          r_item;
    logic [CAP_W-1:0]  r_fill [NUM_STACKS];
    logic [DATA_W-1:0] r_rdata;
    logic              r_use_rdata;
    logic              r_empty;
    logic [1:0]        r_status;

    logic [CAP_W-1:0]  cap_eff;
    logic              sel_ok;
    logic [CAP_W-1:0]  fill;
    logic [IW-1:0]     base;
    logic [CAP_W-1:0]  offset;
    logic [IW-1:0]     idx;
    logic [AW-1:0]     addr;
    logic              is_push;
    logic              is_read;
    logic              empty;
    logic              full;
    logic              do_write;
    logic              do_read;
    logic [1:0]        status;

    always_comb begin
        cap_eff = (i_capacity > CAP_LIMIT) ? CAP_LIMIT : i_capacity;
        sel_ok  = (r_item.stack_select != SEL_NONE);
        fill    = sel_ok ? r_fill[r_item.stack_select] : '0;
        is_push = (r_item.action == ACT_PUSH);
        is_read = (r_item.action == ACT_POP) || (r_item.action == ACT_PEEK);
        empty   = (fill == '0);
        full    = (fill >= cap_eff);

        unique case (r_item.stack_select)
            2'd1:    base = IW'(cap_eff);
            2'd2:    base = IW'({cap_eff, 1'b0});
            default: base = '0;
        endcase

        offset = is_push ? fill : (fill - 1'b1);
        idx    = base + IW'(offset);
        addr   = idx[AW-1:0];

        do_write = sel_ok && is_push && !full;
        do_read  = sel_ok && is_read && !empty;

        // the unused stack select reads as always empty, and a push to it reports full
        priority if (is_push && (!sel_ok || full)) begin
            status = STAT_FULL;
        end else if (is_read && (!sel_ok || empty)) begin
            status = STAT_EMPTY;
        end else begin
            status = STAT_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            if (do_write) begin
                mem[addr] <= r_item.push_value;
            end
            r_rdata     <= mem[addr];
            r_use_rdata <= do_read;
            r_empty     <= empty;
            r_status    <= status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_STACKS; s++) begin
                r_fill[s] <= '0;
            end
        end else if (i_cmd.exec && sel_ok) begin
            if (do_write) begin
                r_fill[r_item.stack_select] <= fill + 1'b1;
            end else if (do_read && (r_item.action == ACT_POP)) begin
                r_fill[r_item.stack_select] <= fill - 1'b1;
            end
        end
    end

    assign o_result.read_value  = r_use_rdata ? r_rdata : '1;
    assign o_result.stack_empty = r_empty;
    assign o_result.status      = r_status;

endmodule
